FILE: design/ble_adv_mfg_filter_parser_defines.svh
// Assertion macros used by the verification file of the advertisement filter.
// No dependencies; the user supplies i_clk and i_rst_n in scope.
`ifndef BLE_ADV_MFG_FILTER_PARSER_DEFINES_SVH
`define BLE_ADV_MFG_FILTER_PARSER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BAMFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BAMFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: design/bamfp_pkg.sv
// Shared types and constants for the advertisement manufacturer-structure filter.
// No dependencies.
`default_nettype none

package bamfp_pkg;

    // Frame format
    localparam logic [7:0] MFG_TYPE       = 8'hFF;
    localparam logic [7:0] MFG_DATA_LEN   = 8'd24;
    localparam logic [7:0] MAX_ADV_LEN    = 8'd31;
    localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;

    // Positions inside the manufacturer data
    localparam logic [4:0] POS_COMPANY_LO = 5'd0;
    localparam logic [4:0] POS_COMPANY_HI = 5'd1;
    localparam logic [4:0] POS_VENDOR_LO  = 5'd5;
    localparam logic [4:0] POS_VENDOR_HI  = 5'd6;
    localparam logic [4:0] POS_PRODUCT_LO = 5'd7;
    localparam logic [4:0] POS_PRODUCT_HI = 5'd8;
    localparam logic [4:0] POS_FLAG       = 5'd11;
    localparam logic [4:0] POS_ADDR_FIRST = 5'd12;
    localparam logic [4:0] POS_ADDR_END   = 5'd18;

    // Register port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [15:0] COMPANY_ID_RESET = 16'h0553;
    localparam logic [15:0] VENDOR_ID_RESET  = 16'h057E;

    typedef enum logic {
        REG_COMPANY_ID = 1'b0,
        REG_VENDOR_ID  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [15:0] product_id;
        logic [7:0]  wake_flag;
        logic [47:0] controller_address;
    } t_out_item;

    typedef struct packed {
        logic [15:0] company_id;
        logic [15:0] vendor_id;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/ble_adv_mfg_filter_parser.sv
// Top level of the advertisement manufacturer-structure filter: input register,
// register port and result register around the frame walker. Depends on bamfp_pkg, bamfp_parse.
//
//   Channel   Direction  Handshake                        Payload
//   -------   ---------  -------------------------------  ------------------------
//   in        sink       i_in_valid  / o_in_stall         i_in_item  (t_in_item)
//   out       source     o_out_valid / i_out_stall        o_out_item (t_out_item)
//   cfg       sink       psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One byte per cycle is sustained unless a marked byte stalls; the walker steps once per byte.
// A marked byte's verdict is registered in the result register, behind the input register.
// A stall on the output holds a marked byte in the input register; unmarked bytes keep flowing.
// Synchronous active-low reset clears all control and frame state and loads the
// company id 0x0553 and vendor id 0x057E.
`default_nettype none

module ble_adv_mfg_filter_parser (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // byte input
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  bamfp_pkg::t_in_item                  i_in_item,
    // result output
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output bamfp_pkg::t_out_item                 o_out_item,
    // register port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [bamfp_pkg::PADDR_W-1:0]        paddr,
    input  wire  [bamfp_pkg::PDATA_W-1:0]        pwdata,
    output logic [bamfp_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);
    import bamfp_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item result;
    logic      out_free;
    logic      s1_go;
    logic      in_take;
    logic      cfg_write;

    // The result register frees up when empty or when its transfer completes.
    assign out_free   = !r_out_valid || !i_out_stall;
    // Unmarked bytes never need the result register; a marked byte waits for it.
    assign s1_go      = r_s1_valid && (!r_s1_item.last_byte || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Payload register: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in_item;
        end
    end

    bamfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s1_go),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Result register: capture the verdict of a marked byte, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_item.last_byte) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Register port: zero wait states; low address bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.company_id <= COMPANY_ID_RESET;
            r_cfg.vendor_id  <= VENDOR_ID_RESET;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_COMPANY_ID: r_cfg.company_id <= pwdata[15:0];
                REG_VENDOR_ID:  r_cfg.vendor_id  <= pwdata[15:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_COMPANY_ID: prdata = {16'd0, r_cfg.company_id};
            REG_VENDOR_ID:  prdata = {16'd0, r_cfg.vendor_id};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bamfp_parse.sv
// Frame walker: holds the per-frame parse state and forms the verdict on the last byte.
// Depends on bamfp_pkg.
`default_nettype none

module bamfp_parse (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_go,
    input  bamfp_pkg::t_in_item  i_item,
    input  bamfp_pkg::t_cfg      i_cfg,
    output bamfp_pkg::t_out_item o_result
);
    import bamfp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_byte_count,   n_byte_count;
    logic [7:0]  r_bytes_left,   n_bytes_left;
    logic [4:0]  r_body_index,   n_body_index;
    logic        r_in_mfg,       n_in_mfg;
    logic        r_failed,       n_failed;
    logic        r_found,        n_found;
    logic        r_stopped,      n_stopped;
    logic [15:0] r_held_product, n_held_product;
    logic [7:0]  r_held_flag,    n_held_flag;
    logic [47:0] r_held_address, n_held_address;

    always_comb begin
        logic [7:0] left_dec;
        logic       mfg_now;
        logic       check_end;
        logic       ok;
        logic [4:0] addr_off;
        logic [7:0] b;

        b              = i_item.data_byte;
        left_dec       = r_bytes_left - 8'd1;
        addr_off       = r_body_index - POS_ADDR_FIRST;
        mfg_now        = r_in_mfg;
        check_end      = 1'b0;
        n_phase        = r_phase;
        n_byte_count   = (r_byte_count == BYTE_COUNT_MAX) ? r_byte_count
                                                          : r_byte_count + 8'd1;
        n_bytes_left   = r_bytes_left;
        n_body_index   = r_body_index;
        n_in_mfg       = r_in_mfg;
        n_failed       = r_failed;
        n_found        = r_found;
        n_stopped      = r_stopped;
        n_held_product = r_held_product;
        n_held_flag    = r_held_flag;
        n_held_address = r_held_address;

        if (!r_stopped && !r_failed) begin
            case (r_phase)
                PH_LEN: begin
                    // a length byte in the final position is dropped
                    if (!i_item.last_byte) begin
                        if (b == 8'd0) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_bytes_left = b;
                            n_phase      = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    mfg_now      = (b == MFG_TYPE);
                    n_bytes_left = left_dec;
                    n_body_index = 5'd0;
                    n_in_mfg     = mfg_now;
                    if (mfg_now && left_dec != MFG_DATA_LEN) begin
                        n_failed = 1'b1;
                    end else begin
                        check_end = 1'b1;
                    end
                end
                PH_BODY: begin
                    if (r_in_mfg) begin
                        case (r_body_index)
                            POS_COMPANY_LO: if (b != i_cfg.company_id[7:0])  n_failed = 1'b1;
                            POS_COMPANY_HI: if (b != i_cfg.company_id[15:8]) n_failed = 1'b1;
                            POS_VENDOR_LO:  if (b != i_cfg.vendor_id[7:0])   n_failed = 1'b1;
                            POS_VENDOR_HI:  if (b != i_cfg.vendor_id[15:8])  n_failed = 1'b1;
                            POS_PRODUCT_LO: n_held_product[7:0]  = b;
                            POS_PRODUCT_HI: n_held_product[15:8] = b;
                            POS_FLAG:       n_held_flag          = b;
                            default: begin
                                if (r_body_index >= POS_ADDR_FIRST &&
                                    r_body_index < POS_ADDR_END) begin
                                    n_held_address[addr_off[2:0] * 8 +: 8] = b;
                                end
                            end
                        endcase
                    end
                    n_bytes_left = left_dec;
                    n_body_index = r_body_index + 5'd1;
                    check_end    = 1'b1;
                end
                default: begin
                    n_phase = PH_LEN;
                end
            endcase

            if (check_end) begin
                if (left_dec == 8'd0) begin
                    if (mfg_now) n_found = 1'b1;
                    n_in_mfg = 1'b0;
                    n_phase  = PH_LEN;
                end else begin
                    n_phase = PH_BODY;
                    // structure runs past the frame end
                    if (i_item.last_byte) n_failed = 1'b1;
                end
            end
        end

        ok = n_found && !n_failed && (n_byte_count <= MAX_ADV_LEN);
        o_result.accepted           = ok;
        o_result.product_id         = ok ? n_held_product : 16'd0;
        o_result.wake_flag          = ok ? n_held_flag    : 8'd0;
        o_result.controller_address = ok ? n_held_address : 48'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_item.last_byte)) begin
            r_phase        <= PH_LEN;
            r_byte_count   <= 8'd0;
            r_bytes_left   <= 8'd0;
            r_body_index   <= 5'd0;
            r_in_mfg       <= 1'b0;
            r_failed       <= 1'b0;
            r_found        <= 1'b0;
            r_stopped      <= 1'b0;
            r_held_product <= 16'd0;
            r_held_flag    <= 8'd0;
            r_held_address <= 48'd0;
        end else if (i_go) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_bytes_left   <= n_bytes_left;
            r_body_index   <= n_body_index;
            r_in_mfg       <= n_in_mfg;
            r_failed       <= n_failed;
            r_found        <= n_found;
            r_stopped      <= n_stopped;
            r_held_product <= n_held_product;
            r_held_flag    <= n_held_flag;
            r_held_address <= n_held_address;
        end
    end

endmodule

`default_nettype wire

FILE: design/bamfp_checker.sv
// Port-level checks for the advertisement filter, bound to the top level.
// Depends on bamfp_pkg and ble_adv_mfg_filter_parser_defines.svh.
`default_nettype none
`include "ble_adv_mfg_filter_parser_defines.svh"

module bamfp_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           o_out_valid,
    input wire                           i_out_stall,
    input bamfp_pkg::t_out_item          o_out_item,
    input wire                           psel,
    input wire                           penable,
    input wire                           pwrite,
    input wire [bamfp_pkg::PADDR_W-1:0]  paddr,
    input wire [bamfp_pkg::PDATA_W-1:0]  pwdata,
    input wire [bamfp_pkg::PDATA_W-1:0]  prdata,
    input wire                           pready
);
    import bamfp_pkg::*;

    `BAMFP_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `BAMFP_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_item), "stalled result changed")
    `BAMFP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid right after reset")
    `BAMFP_ASSERT(a_reject_zero, o_out_valid && !o_out_item.accepted |-> o_out_item.product_id == 16'd0 && o_out_item.wake_flag == 8'd0 && o_out_item.controller_address == 48'd0, "rejected frame carries data")
    `BAMFP_ASSERT(a_cfg_readback, psel && penable && pwrite && pready ##1 psel && !pwrite && paddr[2] == $past(paddr[2]) |-> prdata == {16'd0, $past(pwdata[15:0])}, "register readback mismatch")

endmodule

bind ble_adv_mfg_filter_parser bamfp_checker u_bamfp_checker (.*);

`default_nettype wire
